>>> sv/i2crs_pkg.sv
`timescale 1ns / 1ps

package i2crs_pkg;

   localparam int ADDR_WIDTH  = 7;
   localparam int BYTE_WIDTH  = 8;
   localparam int VALUE_WIDTH = 16;

   // Bus events delivered by the line controller.
   typedef enum logic [1:0] {
      OP_BEGIN = 2'd0,
      OP_ACK   = 2'd1,
      OP_NACK  = 2'd2,
      OP_BYTE  = 2'd3
   } op_type;

   // Direction bit appended to the slave address.
   localparam logic RW_WRITE = 1'b0;
   localparam logic RW_READ  = 1'b1;

   typedef enum logic [5:0] {
      PH_IDLE    = 6'b000001,
      PH_START   = 6'b000010,
      PH_MEASURE = 6'b000100,
      PH_PROCESS = 6'b001000,
      PH_HIGH    = 6'b010000,
      PH_LOW     = 6'b100000
   } phase_type;

   typedef struct packed {
      op_type                  op;
      logic [ADDR_WIDTH-1:0]   slave_address;
      logic [BYTE_WIDTH-1:0]   register_address;
      logic [BYTE_WIDTH-1:0]   rx_byte;
   } req_payload_type;

   // Contents of the input register handed to the sequencer.
   typedef struct packed {
      logic            valid;
      req_payload_type data;
   } stage_type;

   typedef struct packed {
      logic                    issue_start;
      logic                    issue_stop;
      logic                    issue_ack;
      logic                    issue_nack;
      logic                    tx_valid;
      logic [BYTE_WIDTH-1:0]   tx_byte;
      logic                    finished;
      logic [VALUE_WIDTH-1:0]  read_value;
      logic                    protocol_error;
      logic                    busy_res;
   } rsp_payload_type;

endpackage

>>> sv/i2crs_req_if.sv
`timescale 1ns / 1ps

interface i2crs_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] op;
   logic [6:0] slave_address;
   logic [7:0] register_address;
   logic [7:0] rx_byte;

   modport source (output valid, output op, output slave_address,
                   output register_address, output rx_byte, input ready);
   modport sink   (input valid, input op, input slave_address,
                   input register_address, input rx_byte, output ready);
endinterface

>>> sv/i2crs_rsp_if.sv
`timescale 1ns / 1ps

interface i2crs_rsp_if;
   logic        valid;
   logic        ready;
   logic        issue_start;
   logic        issue_stop;
   logic        issue_ack;
   logic        issue_nack;
   logic        tx_valid;
   logic [7:0]  tx_byte;
   logic        finished;
   logic [15:0] read_value;
   logic        protocol_error;
   logic        busy_res;

   modport source (output valid, output issue_start, output issue_stop,
                   output issue_ack, output issue_nack, output tx_valid,
                   output tx_byte, output finished, output read_value,
                   output protocol_error, output busy_res, input ready);
   modport sink   (input valid, input issue_start, input issue_stop,
                   input issue_ack, input issue_nack, input tx_valid,
                   input tx_byte, input finished, input read_value,
                   input protocol_error, input busy_res, output ready);
endinterface

>>> sv/i2crs_input_stage.sv
`timescale 1ns / 1ps

module i2crs_input_stage (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  i2crs_pkg::req_payload_type in_data,
   output logic                       in_ready,
   input  logic                       advance,
   output i2crs_pkg::stage_type       stage
);
   import i2crs_pkg::*;

   logic            valid_ff;
   logic            valid_in;
   req_payload_type data_ff;
   logic            take;

   // The register may refill in the same cycle that it drains.
   assign in_ready = !valid_ff || advance;
   assign take     = in_valid && in_ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= in_data;
      end
   end

   assign stage.valid = valid_ff;
   assign stage.data  = data_ff;

endmodule

>>> sv/i2crs_sequencer.sv
`timescale 1ns / 1ps

module i2crs_sequencer (
   input  logic                       clock,
   input  logic                       reset,
   input  i2crs_pkg::stage_type       stage,
   output logic                       advance,
   output logic                       out_valid,
   input  logic                       out_ready,
   output i2crs_pkg::rsp_payload_type out_data
);
   import i2crs_pkg::*;

   phase_type                phase_ff, phase_in;
   logic [VALUE_WIDTH-1:0]   assembled_ff, assembled_in;
   logic [ADDR_WIDTH-1:0]    held_sa_ff, held_sa_in;
   logic [BYTE_WIDTH-1:0]    held_reg_ff, held_reg_in;
   logic [BYTE_WIDTH-1:0]    held_high_ff, held_high_in;
   logic                     res_valid_ff;
   rsp_payload_type          res_ff, res_in;
   logic                     fire;
   logic                     err;

   assign advance = !res_valid_ff || out_ready;
   assign fire    = stage.valid && advance;

   always_comb begin
      phase_in     = phase_ff;
      assembled_in = assembled_ff;
      held_sa_in   = held_sa_ff;
      held_reg_in  = held_reg_ff;
      held_high_in = held_high_ff;
      res_in       = '0;
      err          = 1'b0;

      case (stage.data.op)
         OP_BEGIN: begin
            if (phase_ff == PH_IDLE) begin
               held_sa_in         = stage.data.slave_address;
               held_reg_in        = stage.data.register_address;
               phase_in           = PH_START;
               res_in.issue_start = 1'b1;
               res_in.tx_valid    = 1'b1;
               res_in.tx_byte     = {stage.data.slave_address, RW_WRITE};
            end else begin
               err = 1'b1;
            end
         end
         OP_ACK: begin
            case (phase_ff)
               PH_START: begin
                  phase_in        = PH_MEASURE;
                  res_in.tx_valid = 1'b1;
                  res_in.tx_byte  = held_reg_ff;
               end
               PH_MEASURE: begin
                  phase_in           = PH_PROCESS;
                  res_in.issue_start = 1'b1;
                  res_in.tx_valid    = 1'b1;
                  res_in.tx_byte     = {held_sa_ff, RW_READ};
               end
               PH_PROCESS: begin
                  phase_in = PH_HIGH;
               end
               default: begin
                  err = 1'b1;
               end
            endcase
         end
         OP_NACK: begin
            // A refused read address is retried with another repeated START.
            if (phase_ff == PH_PROCESS) begin
               res_in.issue_start = 1'b1;
               res_in.tx_valid    = 1'b1;
               res_in.tx_byte     = {held_sa_ff, RW_READ};
            end else begin
               err = 1'b1;
            end
         end
         OP_BYTE: begin
            case (phase_ff)
               PH_HIGH: begin
                  held_high_in     = stage.data.rx_byte;
                  phase_in         = PH_LOW;
                  res_in.issue_ack = 1'b1;
               end
               PH_LOW: begin
                  assembled_in      = {held_high_ff, stage.data.rx_byte};
                  phase_in          = PH_IDLE;
                  res_in.issue_nack = 1'b1;
                  res_in.issue_stop = 1'b1;
                  res_in.finished   = 1'b1;
               end
               default: begin
                  err = 1'b1;
               end
            endcase
         end
         default: begin
            err = 1'b1;
         end
      endcase

      res_in.protocol_error = err;
      res_in.read_value     = assembled_in;
      res_in.busy_res       = (phase_in != PH_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         assembled_ff <= '0;
         held_sa_ff   <= '0;
         held_reg_ff  <= '0;
         held_high_ff <= '0;
         res_valid_ff <= 1'b0;
      end else begin
         if (fire) begin
            phase_ff     <= phase_in;
            assembled_ff <= assembled_in;
            held_sa_ff   <= held_sa_in;
            held_reg_ff  <= held_reg_in;
            held_high_ff <= held_high_in;
         end
         if (advance) begin
            res_valid_ff <= stage.valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         res_ff <= res_in;
      end
   end

   assign out_valid = res_valid_ff;
   assign out_data  = res_ff;

endmodule

>>> sv/i2c_register_read_sequencer_unit.sv
`timescale 1ns / 1ps
// A transaction accepted on req_chan is loaded into the request register, then into
// the result register when the sequencer takes it, and is then offered on rsp_chan.
// Throughput: one event per cycle unless rsp_chan stalls, set by the sequencer's phase update.
// The request register refills in the cycle it drains, so no bubble appears under load.
// Reset is synchronous and active high; it returns the phase to idle, clears the read
// value and held addresses, and empties both the request and the result registers.

module i2c_register_read_sequencer_unit (
   input  logic     clock,
   input  logic     reset,
   i2crs_req_if.sink   req_chan,
   i2crs_rsp_if.source rsp_chan
);
   import i2crs_pkg::*;

   req_payload_type req_data;
   stage_type       stage;
   logic            advance;
   rsp_payload_type rsp_data;

   // Gather the request fields into one payload word for the input register.
   assign req_data.op               = op_type'(req_chan.op);
   assign req_data.slave_address    = req_chan.slave_address;
   assign req_data.register_address = req_chan.register_address;
   assign req_data.rx_byte          = req_chan.rx_byte;

   // The input register holds one bus event until the sequencer can take it.
   i2crs_input_stage u_input_stage (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_chan.valid),
      .in_data  (req_data),
      .in_ready (req_chan.ready),
      .advance  (advance),
      .stage    (stage)
   );

   // The sequencer owns the phase and the held bytes. It updates them in the
   // same edge that loads the result register, so back-to-back events each
   // see the state left by the one before.
   i2crs_sequencer u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .stage     (stage),
      .advance   (advance),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (rsp_data)
   );

   // Spread the result word onto the response interface.
   assign rsp_chan.issue_start    = rsp_data.issue_start;
   assign rsp_chan.issue_stop     = rsp_data.issue_stop;
   assign rsp_chan.issue_ack      = rsp_data.issue_ack;
   assign rsp_chan.issue_nack     = rsp_data.issue_nack;
   assign rsp_chan.tx_valid       = rsp_data.tx_valid;
   assign rsp_chan.tx_byte        = rsp_data.tx_byte;
   assign rsp_chan.finished       = rsp_data.finished;
   assign rsp_chan.read_value     = rsp_data.read_value;
   assign rsp_chan.protocol_error = rsp_data.protocol_error;
   assign rsp_chan.busy_res       = rsp_data.busy_res;

`ifndef NO_ASSERTIONS
   // A rejected event must not request any bus action.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.protocol_error) |->
         !(rsp_chan.issue_start || rsp_chan.issue_stop || rsp_chan.issue_ack ||
           rsp_chan.issue_nack || rsp_chan.tx_valid || rsp_chan.finished))
      else $error("protocol error result requests a bus action");

   // A completed read closes with NACK and STOP and leaves the bus idle.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.finished) |->
         (rsp_chan.issue_nack && rsp_chan.issue_stop && !rsp_chan.busy_res))
      else $error("finished result without NACK and STOP or still busy");

   // A START is always followed by an address byte.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.issue_start) |-> rsp_chan.tx_valid)
      else $error("START requested without an address byte");

   // With no byte to send, the byte field reads as zero.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.tx_valid) |-> (rsp_chan.tx_byte == 8'd0))
      else $error("tx_byte not zero while tx_valid is low");
`endif

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import i2crs_pkg::*;

   // Run length and safety limits. The cycle limit covers the slowest legal run,
   // with every transaction waiting out a full sender gap and a full receiver
   // stall, and then adds a wide margin on top.
   localparam int unsigned EVENT_TARGET = 1500;
   localparam int unsigned CALM_AFTER   = 1300;
   localparam int unsigned DRAIN_AT     = 700;
   localparam int unsigned SETTLE_TIME  = 10;
   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned REPORT_MAX   = 10;

   // Scoreboard. It keeps its own copy of the sequencer state, works out the
   // bus actions that each accepted event must produce, and compares every
   // returned result with the oldest prediction still waiting.
   class read_scoreboard;
      phase_type                phase;
      logic [VALUE_WIDTH-1:0]   last_value;
      logic [ADDR_WIDTH-1:0]    held_slave;
      logic [BYTE_WIDTH-1:0]    held_register;
      logic [BYTE_WIDTH-1:0]    held_high;
      rsp_payload_type          pending_actions[$];
      int unsigned              failures;

      function new();
         phase         = PH_IDLE;
         last_value    = '0;
         held_slave    = '0;
         held_register = '0;
         held_high     = '0;
         failures      = 0;
      endfunction

      // Advances the private state by one bus event and returns the actions
      // the sequencer has to request in answer to it.
      function rsp_payload_type predict_bus_step(req_payload_type ev);
         rsp_payload_type act;
         logic            illegal;
         act     = '0;
         illegal = 1'b0;
         case (ev.op)
            OP_BEGIN: begin
               if (phase == PH_IDLE) begin
                  held_slave      = ev.slave_address;
                  held_register   = ev.register_address;
                  phase           = PH_START;
                  act.issue_start = 1'b1;
                  act.tx_valid    = 1'b1;
                  act.tx_byte     = {held_slave, RW_WRITE};
               end else begin
                  illegal = 1'b1;
               end
            end
            OP_ACK: begin
               if (phase == PH_START) begin
                  phase        = PH_MEASURE;
                  act.tx_valid = 1'b1;
                  act.tx_byte  = held_register;
               end else if (phase == PH_MEASURE) begin
                  phase           = PH_PROCESS;
                  act.issue_start = 1'b1;
                  act.tx_valid    = 1'b1;
                  act.tx_byte     = {held_slave, RW_READ};
               end else if (phase == PH_PROCESS) begin
                  // The read address was taken: nothing to request on the bus.
                  phase = PH_HIGH;
               end else begin
                  illegal = 1'b1;
               end
            end
            OP_NACK: begin
               // A refused read address is simply offered again.
               if (phase == PH_PROCESS) begin
                  act.issue_start = 1'b1;
                  act.tx_valid    = 1'b1;
                  act.tx_byte     = {held_slave, RW_READ};
               end else begin
                  illegal = 1'b1;
               end
            end
            default: begin
               if (phase == PH_HIGH) begin
                  held_high     = ev.rx_byte;
                  phase         = PH_LOW;
                  act.issue_ack = 1'b1;
               end else if (phase == PH_LOW) begin
                  last_value     = {held_high, ev.rx_byte};
                  phase          = PH_IDLE;
                  act.issue_nack = 1'b1;
                  act.issue_stop = 1'b1;
                  act.finished   = 1'b1;
               end else begin
                  illegal = 1'b1;
               end
            end
         endcase
         act.read_value     = last_value;
         act.protocol_error = illegal;
         act.busy_res       = (phase != PH_IDLE);
         return act;
      endfunction

      function void note_request(req_payload_type ev);
         pending_actions.push_back(predict_bus_step(ev));
      endfunction

      function void field_mismatch(string name, logic [15:0] want, logic [15:0] got);
         failures++;
         if (failures <= REPORT_MAX)
            $display("mismatch on %s: expected %h, got %h", name, want, got);
      endfunction

      function void check_response(rsp_payload_type got);
         rsp_payload_type want;
         if (pending_actions.size() == 0) begin
            failures++;
            if (failures <= REPORT_MAX)
               $display("result with no prediction waiting: %p", got);
            return;
         end
         want = pending_actions.pop_front();
         if (got.issue_start !== want.issue_start)
            field_mismatch("issue_start", 16'(want.issue_start), 16'(got.issue_start));
         if (got.issue_stop !== want.issue_stop)
            field_mismatch("issue_stop", 16'(want.issue_stop), 16'(got.issue_stop));
         if (got.issue_ack !== want.issue_ack)
            field_mismatch("issue_ack", 16'(want.issue_ack), 16'(got.issue_ack));
         if (got.issue_nack !== want.issue_nack)
            field_mismatch("issue_nack", 16'(want.issue_nack), 16'(got.issue_nack));
         if (got.tx_valid !== want.tx_valid)
            field_mismatch("tx_valid", 16'(want.tx_valid), 16'(got.tx_valid));
         if (got.tx_byte !== want.tx_byte)
            field_mismatch("tx_byte", 16'(want.tx_byte), 16'(got.tx_byte));
         if (got.finished !== want.finished)
            field_mismatch("finished", 16'(want.finished), 16'(got.finished));
         if (got.read_value !== want.read_value)
            field_mismatch("read_value", want.read_value, got.read_value);
         if (got.protocol_error !== want.protocol_error)
            field_mismatch("protocol_error", 16'(want.protocol_error),
                           16'(got.protocol_error));
         if (got.busy_res !== want.busy_res)
            field_mismatch("busy_res", 16'(want.busy_res), 16'(got.busy_res));
      endfunction

      function int unsigned outstanding();
         return pending_actions.size();
      endfunction

      // Predictions that never got their result count as failures.
      function void close_out();
         if (pending_actions.size() != 0) begin
            failures += pending_actions.size();
            $display("%0d predicted results never arrived", pending_actions.size());
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   int unsigned cycle_count;
   int unsigned events_sent;
   logic        calm;

   i2crs_req_if req_chan ();
   i2crs_rsp_if rsp_chan ();

   read_scoreboard board;

   i2c_register_read_sequencer_unit DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Watchdog. A run that is still going at the limit has hung somewhere.
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Monitor. Both channels are sampled at the rising edge, so what is seen is
   // the value that was present at the edge, before any update made there.
   // A result can never belong to a transaction accepted at the same edge,
   // so the order of the two calls does not matter.
   always @(posedge clock) begin : watch_channels
      req_payload_type ev;
      rsp_payload_type got;
      if (!reset && board != null) begin
         if (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
            got.issue_start    = rsp_chan.issue_start;
            got.issue_stop     = rsp_chan.issue_stop;
            got.issue_ack      = rsp_chan.issue_ack;
            got.issue_nack     = rsp_chan.issue_nack;
            got.tx_valid       = rsp_chan.tx_valid;
            got.tx_byte        = rsp_chan.tx_byte;
            got.finished       = rsp_chan.finished;
            got.read_value     = rsp_chan.read_value;
            got.protocol_error = rsp_chan.protocol_error;
            got.busy_res       = rsp_chan.busy_res;
            board.check_response(got);
         end
         if (req_chan.valid === 1'b1 && req_chan.ready === 1'b1) begin
            ev.op               = op_type'(req_chan.op);
            ev.slave_address    = req_chan.slave_address;
            ev.register_address = req_chan.register_address;
            ev.rx_byte          = req_chan.rx_byte;
            board.note_request(ev);
         end
      end
   end

   // Result side back-pressure. The receiver drops ready for bursts of random length,
   // with long runs of steady ready in between, and stops stalling altogether once
   // the run has entered its calm final stretch.
   initial begin
      rsp_chan.ready <= 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (!calm && $urandom_range(0, 9) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
      end
   end

   // Builds an event of the given kind with every other field random, so the
   // fields that the current event does not use still toggle on the bus.
   function automatic req_payload_type random_event(op_type kind);
      req_payload_type ev;
      ev.op               = kind;
      ev.slave_address    = 7'($urandom_range(0, 127));
      ev.register_address = 8'($urandom_range(0, 255));
      ev.rx_byte          = 8'($urandom_range(0, 255));
      return ev;
   endfunction

   // Presents one event and returns at the edge where it is accepted. Valid
   // stays high when the next event follows straight away; an idle burst
   // first lowers it.
   task automatic send_event(req_payload_type ev);
      if (!calm && $urandom_range(0, 7) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_chan.valid            <= 1'b1;
      req_chan.op               <= ev.op;
      req_chan.slave_address    <= ev.slave_address;
      req_chan.register_address <= ev.register_address;
      req_chan.rx_byte          <= ev.rx_byte;
      @(posedge clock);
      while (req_chan.ready !== 1'b1) @(posedge clock);
      events_sent++;
      if (events_sent >= CALM_AFTER) calm = 1'b1;
   endtask

   // Holds the sender off until every predicted result has come back. It waits
   // on a clock edge before it checks, so valid is never lowered and raised in one step.
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (board.outstanding() != 0);
   endtask

   task automatic send_begin(logic [6:0] slave, logic [7:0] register_index);
      req_payload_type ev;
      ev                  = random_event(OP_BEGIN);
      ev.slave_address    = slave;
      ev.register_address = register_index;
      send_event(ev);
   endtask

   task automatic send_byte(logic [7:0] data);
      req_payload_type ev;
      ev         = random_event(OP_BYTE);
      ev.rx_byte = data;
      send_event(ev);
   endtask

   // One register read as a well-behaved slave would drive it, with up to four
   // read-address refusals. Now and then a stray event is slipped in, or the
   // read is cut short, so that the error paths see mid-transaction phases.
   task automatic run_register_read();
      req_payload_type steps[$];
      int unsigned     refusals;
      steps.push_back(random_event(OP_BEGIN));
      steps.push_back(random_event(OP_ACK));
      steps.push_back(random_event(OP_ACK));
      refusals = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
      repeat (refusals) steps.push_back(random_event(OP_NACK));
      steps.push_back(random_event(OP_ACK));
      steps.push_back(random_event(OP_BYTE));
      steps.push_back(random_event(OP_BYTE));
      foreach (steps[i]) begin
         if ($urandom_range(0, 24) == 0)
            send_event(random_event(op_type'($urandom_range(0, 3))));
         if ($urandom_range(0, 39) == 0)
            return;
         send_event(steps[i]);
      end
   endtask

   initial begin
      logic drained_once;
      board        = new();
      events_sent  = 0;
      calm         = 1'b0;
      drained_once = 1'b0;

      req_chan.valid            <= 1'b0;
      req_chan.op               <= OP_BEGIN;
      req_chan.slave_address    <= '0;
      req_chan.register_address <= '0;
      req_chan.rx_byte          <= '0;
      reset                     <= 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. Events that are illegal while idle come first, then a
      // read with all-ones addresses that meets illegal events in each
      // phase on the way, including a begin while busy and two refusals of
      // the read address. A second read with all-zero addresses and the
      // opposite data extremes follows.
      send_event(random_event(OP_ACK));
      send_event(random_event(OP_NACK));
      send_event(random_event(OP_BYTE));
      send_begin(7'h7F, 8'hFF);
      send_begin(7'h00, 8'h00);
      send_event(random_event(OP_NACK));
      send_event(random_event(OP_BYTE));
      send_event(random_event(OP_ACK));
      send_event(random_event(OP_NACK));
      send_event(random_event(OP_ACK));
      send_event(random_event(OP_NACK));
      send_event(random_event(OP_NACK));
      send_event(random_event(OP_BYTE));
      send_begin(7'h2A, 8'h55);
      send_event(random_event(OP_ACK));
      send_event(random_event(OP_ACK));
      send_event(random_event(OP_NACK));
      send_byte(8'hFF);
      send_event(random_event(OP_ACK));
      send_byte(8'h00);
      send_begin(7'h00, 8'h00);
      send_event(random_event(OP_ACK));
      send_event(random_event(OP_ACK));
      send_event(random_event(OP_ACK));
      send_byte(8'h00);
      send_byte(8'hFF);
      drain_results();

      // Random part: mostly complete reads with random content, plus noise.
      // Once, midway, the sender waits for every result to come home.
      while (events_sent < EVENT_TARGET) begin
         if ($urandom_range(0, 9) == 0)
            send_event(random_event(op_type'($urandom_range(0, 3))));
         else
            run_register_read();
         if (!drained_once && events_sent >= DRAIN_AT) begin
            drain_results();
            drained_once = 1'b1;
         end
      end

      drain_results();
      repeat (SETTLE_TIME) @(posedge clock);
      board.close_out();
      if (board.failures == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
